/* design/ptb_pkg.sv */
package ptb_pkg;

   localparam int ID_BITS   = 4;
   localparam int STEP_BITS = 17;

   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_MODIFY = 2'd1;
   localparam logic [1:0] REQ_DELETE = 2'd2;
   localparam logic [1:0] REQ_TICK   = 2'd3;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_FIRE   = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [ID_BITS-1:0] id;
      logic               acc;
      logic               last;
   } rsp_type;

endpackage

/* design/periodic_timer_bank.sv */
// Bank of periodic countdown timers.
// Request channel (req_valid / req_stall): add, modify, delete or tick.
// Add, modify and delete update the timer at once and answer with one
// status transfer (rsp_result_kind 0, rsp_last 1); an add that arms with
// fire_now first sends a fired transfer for the timer.
// A tick walks all NUM_TIMERS slots through one subtract-and-compare unit,
// one slot per cycle while the walk is not held, reading the period/remaining RAM and writing back armed slots.
// Each firing timer gives one fired transfer in index order, rsp_last on
// the final one; a tick where nothing fires gives no transfer.
// The request side is stalled while a request is being worked.
// Results sit in an output register; a new request is taken while the
// last result still waits. A stalled receiver holds the walk only when a
// second fire must be queued behind a held result.
// Synchronous reset disarms all timers and drops any pending result.
module periodic_timer_bank
   import ptb_pkg::*;
#(
   parameter int NUM_TIMERS  = 16,
   parameter int PERIOD_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_timer_id,
   input  logic [23:0] req_period,
   input  logic        req_fire_now,
   input  logic [15:0] req_elapsed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [3:0]  rsp_fired_id,
   output logic        rsp_accepted,
   output logic        rsp_last
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_TICK   = 2'd1;
   localparam logic [1:0] ST_FLUSH  = 2'd2;
   localparam logic [1:0] ST_STATUS = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [IDX_W-1:0]     ex_idx_ff, ex_idx_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [ID_BITS-1:0]   pend_id_ff, pend_id_in;
   logic [ID_BITS-1:0]   st_id_ff, st_id_in;
   logic                 st_ok_ff, st_ok_in;
   logic                 st_fire_ff, st_fire_in;
   logic                 active_ff [NUM_TIMERS];
   logic                 active_in [NUM_TIMERS];
   logic                 rsp_vld_ff, rsp_vld_in;
   rsp_type              rsp_ff, rsp_in;

   logic                     req_accept;
   logic                     out_free;
   logic                     in_range;
   logic [IDX_W-1:0]         req_idx;
   logic [PERIOD_BITS-1:0]   per_in;
   logic                     per_nz;
   logic                     cur_active;
   logic                     req_ok;
   logic                     arm_wr;

   logic                     ram_wr_en;
   logic [IDX_W-1:0]         ram_wr_addr;
   logic [2*PERIOD_BITS-1:0] ram_wr_data;
   logic [IDX_W-1:0]         ram_rd_addr;
   logic [2*PERIOD_BITS-1:0] ram_rd_data;

   logic                     ex_active;
   logic                     unit_fires;
   logic [PERIOD_BITS-1:0]   unit_next;
   logic                     ex_fire;
   logic                     advance;

   ptb_ram #(
      .WIDTH (2 * PERIOD_BITS),
      .DEPTH (NUM_TIMERS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ptb_unit #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_unit (
      .remaining      (ram_rd_data[PERIOD_BITS-1:0]),
      .period         (ram_rd_data[2*PERIOD_BITS-1:PERIOD_BITS]),
      .step           (step_ff),
      .fires          (unit_fires),
      .next_remaining (unit_next)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign out_free   = !rsp_vld_ff || !rsp_stall;

   assign in_range   = (32'(req_timer_id) < 32'(NUM_TIMERS));
   assign req_idx    = IDX_W'(req_timer_id);
   assign per_in     = PERIOD_BITS'(req_period);
   assign per_nz     = |per_in;
   assign cur_active = in_range && active_ff[req_idx];

   always_comb begin
      unique case (req_type)
         REQ_ADD:    req_ok = in_range && !cur_active && per_nz;
         REQ_MODIFY: req_ok = in_range && per_nz;
         REQ_DELETE: req_ok = cur_active;
         default:    req_ok = 1'b0;
      endcase
   end

   assign arm_wr = req_accept && req_ok &&
                   ((req_type == REQ_ADD) || (req_type == REQ_MODIFY));

   assign ex_active = active_ff[ex_idx_ff];
   assign ex_fire   = ex_active && unit_fires;
   assign advance   = !(ex_fire && pend_vld_ff && !out_free);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = req_idx;
      ram_wr_data = {per_in, per_in};
      ram_rd_addr = '0;
      if (state_ff == ST_IDLE) begin
         ram_wr_en = arm_wr;
      end else if (state_ff == ST_TICK) begin
         ram_wr_en   = advance && ex_active;
         ram_wr_addr = ex_idx_ff;
         ram_wr_data = {ram_rd_data[2*PERIOD_BITS-1:PERIOD_BITS], unit_next};
         ram_rd_addr = advance ? (ex_idx_ff + IDX_W'(1)) : ex_idx_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      ex_idx_in   = ex_idx_ff;
      step_in     = step_ff;
      pend_vld_in = pend_vld_ff;
      pend_id_in  = pend_id_ff;
      st_id_in    = st_id_ff;
      st_ok_in    = st_ok_ff;
      st_fire_in  = st_fire_ff;
      active_in   = active_ff;
      rsp_vld_in  = rsp_vld_ff && rsp_stall;
      rsp_in      = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_type == REQ_TICK) begin
                  state_in    = ST_TICK;
                  ex_idx_in   = '0;
                  step_in     = STEP_BITS'(req_elapsed) + STEP_BITS'(1);
                  pend_vld_in = 1'b0;
               end else begin
                  state_in   = ST_STATUS;
                  st_id_in   = req_timer_id;
                  st_ok_in   = req_ok;
                  st_fire_in = (req_type == REQ_ADD) && req_ok && req_fire_now;
                  if (in_range) begin
                     if (req_type == REQ_MODIFY) begin
                        active_in[req_idx] = per_nz;
                     end else if (req_type == REQ_DELETE) begin
                        active_in[req_idx] = 1'b0;
                     end else if (req_ok) begin
                        active_in[req_idx] = 1'b1;
                     end
                  end
               end
            end
         end
         ST_TICK: begin
            if (advance) begin
               if (ex_fire) begin
                  if (pend_vld_ff) begin
                     rsp_vld_in = 1'b1;
                     rsp_in     = '{kind: KIND_FIRE, id: pend_id_ff, acc: 1'b0,
                                    last: 1'b0};
                  end
                  pend_vld_in = 1'b1;
                  pend_id_in  = ID_BITS'(ex_idx_ff);
               end
               if (ex_idx_ff == LAST_IDX) begin
                  state_in = ST_FLUSH;
               end else begin
                  ex_idx_in = ex_idx_ff + IDX_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_in      = '{kind: KIND_FIRE, id: pend_id_ff, acc: 1'b0, last: 1'b1};
               pend_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               if (st_fire_ff) begin
                  rsp_in     = '{kind: KIND_FIRE, id: st_id_ff, acc: 1'b0, last: 1'b0};
                  st_fire_in = 1'b0;
               end else begin
                  rsp_in   = '{kind: KIND_STATUS, id: st_id_ff, acc: st_ok_ff,
                              last: 1'b1};
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pend_vld_ff <= 1'b0;
         st_fire_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            active_ff[i] <= 1'b0;
         end
      end else begin
         state_ff    <= state_in;
         pend_vld_ff <= pend_vld_in;
         st_fire_ff  <= st_fire_in;
         rsp_vld_ff  <= rsp_vld_in;
         active_ff   <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      ex_idx_ff  <= ex_idx_in;
      step_ff    <= step_in;
      pend_id_ff <= pend_id_in;
      st_id_ff   <= st_id_in;
      st_ok_ff   <= st_ok_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_result_kind = rsp_ff.kind;
   assign rsp_fired_id    = rsp_ff.id;
   assign rsp_accepted    = rsp_ff.acc;
   assign rsp_last        = rsp_ff.last;

endmodule

/* design/ptb_ram.sv */
module ptb_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ptb_unit.sv */
module ptb_unit
   import ptb_pkg::*;
#(
   parameter int PERIOD_BITS = 24
) (
   input  logic [PERIOD_BITS-1:0] remaining,
   input  logic [PERIOD_BITS-1:0] period,
   input  logic [STEP_BITS-1:0]   step,
   output logic                   fires,
   output logic [PERIOD_BITS-1:0] next_remaining
);

   localparam int CW = (PERIOD_BITS > STEP_BITS) ? PERIOD_BITS : STEP_BITS;

   logic [CW-1:0] rem_x;
   logic [CW-1:0] step_x;
   logic [CW-1:0] diff;

   always_comb begin
      rem_x          = CW'(remaining);
      step_x         = CW'(step);
      diff           = rem_x - step_x;
      fires          = (rem_x <= step_x);
      next_remaining = fires ? period : PERIOD_BITS'(diff);
   end

endmodule

/* design/ptb_checker.sv */
module ptb_checker
   import ptb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_result_kind,
   input logic        rsp_accepted,
   input logic        rsp_last
);

   // status always closes its request
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_STATUS) |-> rsp_last)
      else $error("status result without last");

   a_fire_not_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_FIRE) |-> !rsp_accepted)
      else $error("fired result with accepted set");

   // more results still owed, so no new request may be taken
   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request side open before last result");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side not busy after a transfer");

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (.*);
